@@ hw/rtl/ptt_pkg.sv @@
// shared types, register indexes and constants of the projected target tracker
// no dependencies
`default_nettype none
package ptt_pkg;

	localparam int MAX_TRACKS_DEF    = 16;
	localparam int SCREEN_WIDTH_DEF  = 1280;
	localparam int SCREEN_HEIGHT_DEF = 720;

	// configuration register indexes
	localparam logic [2:0] REG_FOCAL_X     = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y     = 3'd1;
	localparam logic [2:0] REG_CENTER_X    = 3'd2;
	localparam logic [2:0] REG_CENTER_Y    = 3'd3;
	localparam logic [2:0] REG_MIN_DEPTH   = 3'd4;
	localparam logic [2:0] REG_ALPHA_FLOOR = 3'd5;
	localparam logic [2:0] REG_ALPHA_GAIN  = 3'd6;

	localparam logic [23:0] FOCAL_X_RST     = 24'd412877;
	localparam logic [23:0] FOCAL_Y_RST     = 24'd412877;
	localparam logic [23:0] CENTER_X_RST    = 24'd163840;
	localparam logic [23:0] CENTER_Y_RST    = 24'd92160;
	localparam logic [31:0] MIN_DEPTH_RST   = 32'd19661;
	localparam logic [16:0] ALPHA_FLOOR_RST = 17'd32768;
	localparam logic [16:0] ALPHA_GAIN_RST  = 17'd6554;

	localparam logic OP_DETECT = 1'b0;
	localparam logic OP_FRAME  = 1'b1;

	// fixed point constants, pixels in Q.8
	localparam logic [32:0] NORM_SPAN_Q8    = 33'd2560;
	localparam logic [32:0] MATCH_D2_LIMIT  = 33'd2621440000;
	localparam logic [31:0] RADIUS_FLOOR_Q8 = 32'd1280;
	localparam logic [2:0]  MISS_LIMIT      = 3'd5;
	localparam logic [17:0] ALPHA_ONE       = 18'd65536;
	localparam int          RESULT_CAP      = 16;

	// divider size: 24x32 bit products over a 33 bit divisor
	localparam int DIV_NUM_W = 56;
	localparam int DIV_DEN_W = 33;

	typedef struct packed {
		logic        op;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] size_w;
		logic [31:0] size_h;
	} item_t;

	typedef struct packed {
		logic        has_track;
		logic [3:0]  track_slot;
		logic [10:0] pixel_u;
		logic [9:0]  pixel_v;
		logic [15:0] draw_radius;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [23:0] focal_x;
		logic [23:0] focal_y;
		logic [23:0] center_x;
		logic [23:0] center_y;
		logic [31:0] min_depth;
		logic [16:0] alpha_floor;
		logic [16:0] alpha_gain;
	} cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/ptt_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module ptt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(DEPTH+1)-1:0]      wr_addr,
	input  wire logic [WIDTH-1:0]                wr_data,
	input  wire logic                            rd_en,
	input  wire logic [$clog2(DEPTH+1)-1:0]      rd_addr,
	output logic      [WIDTH-1:0]                rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr[AW-1:0]];
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/ptt_fifo.sv @@
// small register queue used on the item side and the result side
// no dependencies
`default_nettype none
module ptt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/ptt_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// depends on ptt_pkg for default sizes
`default_nettype none
module ptt_div
	import ptt_pkg::*;
#(
	parameter int NW = DIV_NUM_W,
	parameter int DW = DIV_DEN_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic      [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] shq_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q, shq_q[NW-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign done   = done_q;
	assign quot   = shq_q;

	always_ff @(posedge clk) begin
		if (start) begin
			shq_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			shq_q <= {shq_q[NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/ptt_front.sv @@
// front end: takes input words, drops detections that are too near, queues the rest
// depends on ptt_pkg and ptt_fifo
`default_nettype none
module ptt_front
	import ptt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire item_t       item_in,
	input  wire logic [31:0] min_depth,
	output logic             item_valid,
	output item_t            item_out,
	input  wire logic        item_pop
);
	logic keep, q_empty, z_pos;

	// depth test: z must be positive and at least min_depth
	assign z_pos = !item_in.pos_z[31] && (item_in.pos_z != '0);
	assign keep  = (item_in.op == OP_FRAME) ||
	               (z_pos && ({1'b0, item_in.pos_z} >= {1'b0, min_depth}));
	assign item_valid = !q_empty;

	ptt_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(2)
	) u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push && keep),
		.wr_data(item_in),
		.full   (full),
		.rd_en  (item_pop),
		.rd_data(item_out),
		.empty  (q_empty)
	);
endmodule
`default_nettype wire

@@ hw/rtl/ptt_back.sv @@
// back end: projection, nearest track match, adaptive smoothing and frame emission
// depends on ptt_pkg, ptt_div and ptt_ram
`default_nettype none
module ptt_back
	import ptt_pkg::*;
#(
	parameter int MAX_TRACKS    = MAX_TRACKS_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire logic    item_valid,
	input  wire item_t   item,
	output logic         item_pop,
	output logic         res_push,
	output result_t      res_word,
	input  wire logic    res_full
);
	localparam int SLOT_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
	localparam int RCAP_W = $clog2(RESULT_CAP + 1);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_MUL     = 5'd1;
	localparam logic [4:0] ST_DSTART  = 5'd2;
	localparam logic [4:0] ST_DWAIT   = 5'd3;
	localparam logic [4:0] ST_PROJ    = 5'd4;
	localparam logic [4:0] ST_W_RD    = 5'd5;
	localparam logic [4:0] ST_W_DIFF  = 5'd6;
	localparam logic [4:0] ST_W_CMP   = 5'd7;
	localparam logic [4:0] ST_PICK    = 5'd8;
	localparam logic [4:0] ST_SQRT    = 5'd9;
	localparam logic [4:0] ST_WT      = 5'd10;
	localparam logic [4:0] ST_ALPHA   = 5'd12;
	localparam logic [4:0] ST_BL_U    = 5'd13;
	localparam logic [4:0] ST_BL_V    = 5'd14;
	localparam logic [4:0] ST_R_DIFF  = 5'd15;
	localparam logic [4:0] ST_BL_R    = 5'd16;
	localparam logic [4:0] ST_WRITE   = 5'd17;
	localparam logic [4:0] ST_E_RD    = 5'd18;
	localparam logic [4:0] ST_E_CHK   = 5'd19;
	localparam logic [4:0] ST_E_FIN   = 5'd20;

	logic [4:0] state_q;

	// slot flags
	logic [MAX_TRACKS-1:0] used_q, matched_q;
	logic [2:0]            misses_q [MAX_TRACKS];

	// item and projection
	logic [31:0] x_q, y_q, z_q, w_q, h_q;
	logic [1:0]  ph_q;
	logic [55:0] prod_q, qu_q, qv_q, qr_q;
	logic [31:0] ru_q, rv_q, rr_q;

	// match walk
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  best_q;
	logic              found_q;
	logic [32:0]       best_d2_q;
	logic [15:0]       adu_q, adv_q;

	// sqrt and weight
	logic [33:0] sq_n_q, sq_bit_q, sq_res_q;
	logic [32:0] wd_q;
	logic        wsel_q;
	logic [16:0] norm_q, alpha_q;
	logic [31:0] nu_q, nv_q;

	// frame emission
	logic [RCAP_W-1:0] cnt_q;
	logic              pend_v_q;
	result_t           pend_q;

	// ram and divider
	logic          ram_wr, ram_rd;
	logic [CNT_W-1:0] ram_wa, ram_ra;
	logic [95:0]   ram_wd, ram_q;
	logic [31:0]   fu, fv, fr;
	logic          div_start, div_done;
	logic [55:0]   div_num, div_q;
	logic [32:0]   div_den;

	assign fu = ram_q[31:0];
	assign fv = ram_q[63:32];
	assign fr = ram_q[95:64];

	ptt_ram #(
		.WIDTH(96),
		.DEPTH(MAX_TRACKS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_en  (ram_rd),
		.rd_addr(ram_ra),
		.rd_data(ram_q)
	);

	ptt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_q)
	);

	// ---------------- datapath helpers ----------------
	logic [31:0] abs_x, abs_y, min_wh;
	logic [23:0] mul_a;
	logic [31:0] mul_b;
	assign abs_x  = x_q[31] ? (~x_q + 32'd1) : x_q;
	assign abs_y  = y_q[31] ? (~y_q + 32'd1) : y_q;
	assign min_wh = (w_q < h_q) ? w_q : h_q;

	always_comb begin
		case (ph_q)
			2'd0:    begin mul_a = cfg.focal_x; mul_b = abs_x;  end
			2'd1:    begin mul_a = cfg.focal_y; mul_b = abs_y;  end
			default: begin mul_a = cfg.focal_x; mul_b = min_wh; end
		endcase
	end

	// projection to saturated Q.8 pixels
	logic signed [57:0] pu_s, pv_s;
	logic [31:0]        ru_n, rv_n, rr_n;
	assign pu_s = (x_q[31] ? -$signed({2'b00, qu_q}) : $signed({2'b00, qu_q}))
	              + $signed({34'd0, cfg.center_x});
	assign pv_s = (y_q[31] ? -$signed({2'b00, qv_q}) : $signed({2'b00, qv_q}))
	              + $signed({34'd0, cfg.center_y});

	function automatic logic [31:0] sat32(input logic signed [57:0] v);
		logic [31:0] r;
		if (v > 58'sd2147483647)       r = 32'h7fff_ffff;
		else if (v < -58'sd2147483648) r = 32'h8000_0000;
		else                           r = v[31:0];
		return r;
	endfunction

	assign ru_n = sat32(pu_s);
	assign rv_n = sat32(pv_s);
	always_comb begin
		rr_n = (qr_q > 56'd2147483647) ? 32'h7fff_ffff : qr_q[31:0];
		if (rr_n < RADIUS_FLOOR_Q8) rr_n = RADIUS_FLOOR_Q8;
	end

	// clamped distance to stored track
	function automatic logic [15:0] clamp_abs(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		logic [32:0]        m;
		d = $signed({a[31], a}) - $signed({b[31], b});
		m = d[32] ? 33'(-d) : 33'(d);
		return (m > 33'd65535) ? 16'hffff : m[15:0];
	endfunction

	logic [32:0] d2;
	assign d2 = 33'({16'd0, adu_q} * {16'd0, adu_q}) + 33'({16'd0, adv_q} * {16'd0, adv_q});

	// integer square root step
	logic [33:0] sq_trial;
	assign sq_trial = sq_res_q + sq_bit_q;

	// below the span, d * 65536 / 2560 is d * 128 / 5, taken by a reciprocal of 5
	logic [18:0] norm_num;
	logic [38:0] norm_prod;
	assign norm_num  = {wd_q[11:0], 7'd0};
	assign norm_prod = {20'd0, norm_num} * 39'd838861;

	// filter weight
	logic [33:0] gain_norm;
	logic [18:0] alpha_sum;
	assign gain_norm = {17'd0, cfg.alpha_gain} * {17'd0, norm_q};
	assign alpha_sum = {2'b00, cfg.alpha_floor} + {1'b0, gain_norm[33:16]};

	// blend: prev + trunc0((cur - prev) * alpha / 65536)
	logic [31:0]        bl_cur, bl_prev, bl_new;
	logic signed [32:0] bl_diff;
	logic signed [50:0] bl_t, bl_sh;
	always_comb begin
		case (state_q)
			ST_BL_U: begin bl_cur = ru_q; bl_prev = fu; end
			ST_BL_V: begin bl_cur = rv_q; bl_prev = fv; end
			default: begin bl_cur = rr_q; bl_prev = fr; end
		endcase
	end
	assign bl_diff = $signed({bl_cur[31], bl_cur}) - $signed({bl_prev[31], bl_prev});
	assign bl_t    = 51'(bl_diff) * $signed({34'd0, alpha_q});
	assign bl_sh   = bl_t[50] ? ((bl_t + 51'sd65535) >>> 16) : (bl_t >>> 16);
	assign bl_new  = bl_prev + bl_sh[31:0];

	logic signed [32:0] rdiff;
	assign rdiff = $signed({rr_q[31], rr_q}) - $signed({fr[31], fr});

	// lowest free slot
	logic             free_ok;
	logic [CNT_W-1:0] free_idx;
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int k = MAX_TRACKS - 1; k >= 0; k--) begin
			if (!used_q[k]) begin
				free_ok  = 1'b1;
				free_idx = CNT_W'(k);
			end
		end
	end

	// frame walk: aging and screen test
	logic [SLOT_W-1:0] si;
	logic [2:0]        mis_inc;
	logic              ages, keep_used;
	assign si        = i_q[SLOT_W-1:0];
	assign ages      = used_q[si] && !matched_q[si];
	assign mis_inc   = misses_q[si] + 3'd1;
	assign keep_used = used_q[si] && !(ages && (mis_inc > MISS_LIMIT));

	function automatic logic [31:0] div256(input logic [31:0] v);
		logic [31:0] t;
		t = v[31] ? (v + 32'd255) : v;
		return {{8{t[31]}}, t[31:8]};
	endfunction

	logic [31:0]       pu, pv, prad;
	logic              on_screen;
	logic [15:0]       half_rad;
	logic [SLOT_W+3:0] slot_ext;
	result_t           new_res;
	assign pu   = div256(fu);
	assign pv   = div256(fv);
	assign prad = div256(fr);
	assign on_screen = !pu[31] && (pu < 32'(SCREEN_WIDTH)) &&
	                   !pv[31] && (pv < 32'(SCREEN_HEIGHT));
	assign half_rad  = prad[31] ? 16'd0 :
	                   ((prad[31:1] > 31'd65535) ? 16'hffff : prad[16:1]);
	assign slot_ext  = {4'd0, si};
	always_comb begin
		new_res             = '0;
		new_res.has_track   = 1'b1;
		new_res.track_slot  = slot_ext[3:0];
		new_res.pixel_u     = pu[10:0];
		new_res.pixel_v     = pv[9:0];
		new_res.draw_radius = half_rad;
		new_res.last        = 1'b0;
	end

	logic emit_here;
	assign emit_here = on_screen && (cnt_q < RCAP_W'(RESULT_CAP));

	// ---------------- control outputs ----------------
	always_comb begin
		item_pop  = 1'b0;
		div_start = 1'b0;
		div_num   = prod_q;
		div_den   = (ph_q == 2'd2) ? {z_q, 1'b0} : {1'b0, z_q};
		ram_rd    = 1'b0;
		ram_ra    = i_q;
		ram_wr    = 1'b0;
		ram_wa    = best_q;
		ram_wd    = {rr_q, rv_q, ru_q};
		res_push  = 1'b0;
		res_word  = pend_q;
		case (state_q)
			ST_IDLE:   item_pop = item_valid;
			ST_DSTART: div_start = 1'b1;
			ST_W_RD:   ram_rd = (i_q != CNT_W'(MAX_TRACKS)) && used_q[si] && !matched_q[si];
			ST_PICK: begin
				ram_rd = found_q;
				ram_ra = best_q;
				ram_wr = !found_q && free_ok;
				ram_wa = free_idx;
			end
			ST_WRITE: begin
				ram_wr = 1'b1;
				ram_wd = {bl_new, nv_q, nu_q};
			end
			ST_E_RD: ram_rd = (i_q != CNT_W'(MAX_TRACKS)) && keep_used;
			ST_E_CHK: res_push = emit_here && pend_v_q && !res_full;
			ST_E_FIN: begin
				res_push = !res_full;
				if (pend_v_q) begin
					res_word      = pend_q;
					res_word.last = 1'b1;
				end else begin
					res_word      = '0;
					res_word.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= item.pos_x;
				y_q <= item.pos_y;
				z_q <= item.pos_z;
				w_q <= item.size_w;
				h_q <= item.size_h;
			end
			ST_MUL: prod_q <= 56'(mul_a * mul_b);
			ST_DWAIT: begin
				if (div_done) begin
					case (ph_q)
						2'd0:    qu_q <= div_q;
						2'd1:    qv_q <= div_q;
						default: qr_q <= div_q;
					endcase
				end
			end
			ST_PROJ: begin
				ru_q      <= ru_n;
				rv_q      <= rv_n;
				rr_q      <= rr_n;
				best_d2_q <= MATCH_D2_LIMIT;
			end
			ST_W_DIFF: begin
				adu_q <= clamp_abs(ru_q, fu);
				adv_q <= clamp_abs(rv_q, fv);
			end
			ST_W_CMP: begin
				if (d2 < best_d2_q) begin
					best_d2_q <= d2;
					best_q    <= i_q;
				end
			end
			ST_PICK: begin
				sq_n_q   <= {1'b0, best_d2_q};
				sq_bit_q <= 34'd1 << 32;
				sq_res_q <= '0;
			end
			ST_SQRT: begin
				if (sq_bit_q != '0) begin
					if (sq_n_q >= sq_trial) begin
						sq_n_q   <= sq_n_q - sq_trial;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end else begin
					wd_q   <= {16'd0, sq_res_q[16:0]};
					wsel_q <= 1'b0;
				end
			end
			ST_WT: norm_q <= (wd_q >= NORM_SPAN_Q8) ? 17'd65536 : norm_prod[38:22];
			ST_ALPHA: alpha_q <= (alpha_sum > {1'b0, ALPHA_ONE}) ? 17'd65536 : alpha_sum[16:0];
			ST_BL_U:  nu_q <= bl_new;
			ST_BL_V:  nv_q <= bl_new;
			ST_R_DIFF: begin
				wd_q   <= rdiff[32] ? 33'(-rdiff) : 33'(rdiff);
				wsel_q <= 1'b1;
			end
			ST_E_CHK: begin
				if (emit_here && !(pend_v_q && res_full)) pend_q <= new_res;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			matched_q <= '0;
			for (int k = 0; k < MAX_TRACKS; k++) misses_q[k] <= '0;
			ph_q      <= '0;
			i_q       <= '0;
			found_q   <= 1'b0;
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						i_q      <= '0;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						ph_q     <= '0;
						found_q  <= 1'b0;
						state_q  <= (item.op == OP_FRAME) ? ST_E_RD : ST_MUL;
					end
				end
				ST_MUL:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) begin
						if (ph_q == 2'd2) begin
							state_q <= ST_PROJ;
						end else begin
							ph_q    <= ph_q + 2'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_PROJ: state_q <= ST_W_RD;
				ST_W_RD: begin
					if (i_q == CNT_W'(MAX_TRACKS)) begin
						state_q <= ST_PICK;
					end else if (used_q[si] && !matched_q[si]) begin
						state_q <= ST_W_DIFF;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_W_DIFF: state_q <= ST_W_CMP;
				ST_W_CMP: begin
					if (d2 < best_d2_q) found_q <= 1'b1;
					i_q     <= i_q + CNT_W'(1);
					state_q <= ST_W_RD;
				end
				ST_PICK: begin
					if (found_q) begin
						state_q <= ST_SQRT;
					end else begin
						if (free_ok) begin
							used_q[free_idx[SLOT_W-1:0]]    <= 1'b1;
							matched_q[free_idx[SLOT_W-1:0]] <= 1'b1;
							misses_q[free_idx[SLOT_W-1:0]]  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SQRT: begin
					if (sq_bit_q == '0) state_q <= ST_WT;
				end
				ST_WT:      state_q <= ST_ALPHA;
				ST_ALPHA:   state_q <= wsel_q ? ST_BL_R : ST_BL_U;
				ST_BL_U:    state_q <= ST_BL_V;
				ST_BL_V:    state_q <= ST_R_DIFF;
				ST_R_DIFF:  state_q <= ST_WT;
				ST_BL_R:    state_q <= ST_WRITE;
				ST_WRITE: begin
					matched_q[best_q[SLOT_W-1:0]] <= 1'b1;
					misses_q[best_q[SLOT_W-1:0]]  <= '0;
					state_q <= ST_IDLE;
				end
				ST_E_RD: begin
					if (i_q == CNT_W'(MAX_TRACKS)) begin
						state_q <= ST_E_FIN;
					end else begin
						if (ages) begin
							misses_q[si] <= mis_inc;
							used_q[si]   <= keep_used;
						end
						matched_q[si] <= 1'b0;
						if (keep_used) begin
							state_q <= ST_E_CHK;
						end else begin
							i_q <= i_q + CNT_W'(1);
						end
					end
				end
				ST_E_CHK: begin
					// hold the newest result back so the final one can carry last
					if (!emit_here) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= ST_E_RD;
					end else if (!(pend_v_q && res_full)) begin
						pend_v_q <= 1'b1;
						cnt_q    <= cnt_q + RCAP_W'(1);
						i_q      <= i_q + CNT_W'(1);
						state_q  <= ST_E_RD;
					end
				end
				ST_E_FIN: begin
					if (!res_full) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/projected_target_tracker_unit.sv @@
// projected target tracker: a detection runs three serial divisions for the projection,
// a match walk that visits every slot and reads, diffs and compares each candidate slot,
// and a square root and smoothing on a match; an end of frame visits every slot, checks
// each kept track, emits the last word and may wait on a full result queue. one word
// at a time is worked on; two input words and four results queue up. reset clears the
// track table flags and loads the default camera and filter settings; positions are kept
`default_nettype none
module projected_target_tracker_unit
	import ptt_pkg::*;
#(
	parameter int MAX_TRACKS    = MAX_TRACKS_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        op,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] size_w,
	input  wire logic [31:0] size_h,
	output logic             empty,
	input  wire logic        pop,
	output logic             has_track,
	output logic      [3:0]  track_slot,
	output logic      [10:0] pixel_u,
	output logic      [9:0]  pixel_v,
	output logic      [15:0] draw_radius,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	cfg_t    cfg_q;
	item_t   in_word, q_word;
	logic    q_valid, q_pop;
	logic    res_push, res_full;
	result_t res_word, res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x     <= FOCAL_X_RST;
			cfg_q.focal_y     <= FOCAL_Y_RST;
			cfg_q.center_x    <= CENTER_X_RST;
			cfg_q.center_y    <= CENTER_Y_RST;
			cfg_q.min_depth   <= MIN_DEPTH_RST;
			cfg_q.alpha_floor <= ALPHA_FLOOR_RST;
			cfg_q.alpha_gain  <= ALPHA_GAIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FOCAL_X:     cfg_q.focal_x     <= cfg_data[23:0];
				REG_FOCAL_Y:     cfg_q.focal_y     <= cfg_data[23:0];
				REG_CENTER_X:    cfg_q.center_x    <= cfg_data[23:0];
				REG_CENTER_Y:    cfg_q.center_y    <= cfg_data[23:0];
				REG_MIN_DEPTH:   cfg_q.min_depth   <= cfg_data;
				REG_ALPHA_FLOOR: cfg_q.alpha_floor <= cfg_data[16:0];
				REG_ALPHA_GAIN:  cfg_q.alpha_gain  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_word.op     = op;
		in_word.pos_x  = pos_x;
		in_word.pos_y  = pos_y;
		in_word.pos_z  = pos_z;
		in_word.size_w = size_w;
		in_word.size_h = size_h;
	end

	ptt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item_in   (in_word),
		.min_depth (cfg_q.min_depth),
		.item_valid(q_valid),
		.item_out  (q_word),
		.item_pop  (q_pop)
	);

	ptt_back #(
		.MAX_TRACKS   (MAX_TRACKS),
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(q_valid),
		.item      (q_word),
		.item_pop  (q_pop),
		.res_push  (res_push),
		.res_word  (res_word),
		.res_full  (res_full)
	);

	ptt_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(4)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_word),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_head),
		.empty  (empty)
	);

	assign has_track   = res_head.has_track;
	assign track_slot  = res_head.track_slot;
	assign pixel_u     = res_head.pixel_u;
	assign pixel_v     = res_head.pixel_v;
	assign draw_radius = res_head.draw_radius;
	assign last        = res_head.last;
endmodule
`default_nettype wire
